/* src/array_element_insert_splicer_core_macros.svh */
// ----------------------------------------------------------------------------
// array_element_insert_splicer_core_macros
// Assertion macros for the array insert splicer, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ARRAY_ELEMENT_INSERT_SPLICER_CORE_MACROS_SVH
`define ARRAY_ELEMENT_INSERT_SPLICER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define AEIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition that must never be seen outside reset
`define AEIS_NEVER(lbl, cond, msg) \
  `AEIS_ASSERT(lbl, !(cond), msg)
`else
`define AEIS_ASSERT(lbl, prop, msg)
`define AEIS_NEVER(lbl, cond, msg)
`endif

`endif

/* src/aeis_pkg.sv */
// ----------------------------------------------------------------------------
// aeis_pkg
// Types and constants of the array insert splicer.
// ----------------------------------------------------------------------------
package aeis_pkg;

  // payload widths fixed by the stream format
  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned LengthWidth = 31;
  localparam int unsigned PosWidth    = 32;
  localparam int unsigned DataWidthDefault = 64;

  // result queue sizing
  localparam int unsigned MaxResults = 3;
  localparam int unsigned QueueDepth = 4;

  // register map
  localparam logic [31:0] MaxLenReset = 32'd2147483632;
  localparam logic        RegLegacy   = 1'b0;
  localparam logic        RegMaxLen   = 1'b1;

  // input command codes
  localparam logic CmdHeader  = 1'b0;
  localparam logic CmdElement = 1'b1;

  typedef enum logic [1:0] {
    KIND_RUN      = 2'd0,
    KIND_NULL_ROW = 2'd1,
    KIND_ZERO_POS = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_e;

  // how the open row places its item
  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_AT_SLOT    = 2'd1,
    MODE_PAD_AFTER  = 2'd2,
    MODE_PAD_BEFORE = 2'd3
  } row_mode_e;

  // one result entry without its value bits
  typedef struct packed {
    kind_e                  kind;
    logic                   out_null;
    logic [LengthWidth-1:0] repeat_count;
    logic                   row_end;
    logic                   last;
  } res_t;

endpackage

/* src/array_element_insert_splicer_core.sv */
// Path: an accepted transfer waits in the input register until the result queue has room
// for three results, then its results are written into the queue that feeds the output.
// Throughput: one input item per cycle while each item gives at most one result and the
// output is not stalled; an item giving two or three results (at the insert point) holds
// the input until the single result port drains the four-entry queue to at most one entry.
// Reset: asynchronous, active low; empties the queues, closes any open row, no clearing pass.
// ----------------------------------------------------------------------------
// array_element_insert_splicer_core
// Splices one item into each streamed array row at a 1-based position.
// ----------------------------------------------------------------------------
`include "array_element_insert_splicer_core_macros.svh"

module array_element_insert_splicer_core
  import aeis_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   command_i,
  input  logic signed [PosWidth-1:0] position_i,
  input  logic                   position_null_i,
  input  logic                   array_null_i,
  input  logic [LengthWidth-1:0] source_length_i,
  input  logic [ValueWidth-1:0]  item_value_i,
  input  logic                   item_null_i,
  input  logic [ValueWidth-1:0]  element_value_i,
  input  logic                   element_null_i,
  // output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             kind_o,
  output logic [ValueWidth-1:0]  out_value_o,
  output logic                   out_null_o,
  output logic [LengthWidth-1:0] repeat_count_o,
  output logic                   row_end_o,
  output logic                   last_o,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned PtrWidth = $clog2(QueueDepth);
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);
  localparam int unsigned ArithWidth = PosWidth + 2;
  localparam logic [CntWidth-1:0] QueueFull = CntWidth'(QueueDepth);

  // configuration registers
  logic                   legacy_q;
  logic [LengthWidth-1:0] max_len_q;
  logic                   cfg_write;

  // input register
  logic                   in_valid_q;
  logic                   cmd_q;
  logic [PosWidth-1:0]    pos_q;
  logic                   pos_null_q;
  logic                   arr_null_q;
  logic [LengthWidth-1:0] len_q;
  logic [DataWidth-1:0]   item_val_q;
  logic                   item_null_q;
  logic [DataWidth-1:0]   elem_val_q;
  logic                   elem_null_q;
  logic                   in_take;
  logic                   proc;

  // row state
  logic [LengthWidth-1:0] row_len_q, row_len_d;
  logic [DataWidth-1:0]   held_item_q, held_item_d;
  logic                   held_null_q, held_null_d;
  logic [LengthWidth-1:0] counter_q, counter_d;
  logic [PosWidth-1:0]    slot_q, slot_d;
  row_mode_e              mode_q, mode_d;
  logic                   drop_q, drop_d;

  // header arithmetic
  logic signed [ArithWidth-1:0] pos_s, len_s, max_s, idx_s, neg_s;
  logic signed [ArithWidth-1:0] slot_hdr, newlen_hdr;
  row_mode_e                    mode_hdr;
  logic                         pos_positive;
  logic                         too_long;

  // element bookkeeping
  logic [LengthWidth:0]   c_inc;
  logic                   final_elem;

  // results built for this item
  res_t                   res      [MaxResults];
  logic [DataWidth-1:0]   res_val  [MaxResults];
  logic [1:0]             n_res;
  logic                   cur_item_null;
  logic [DataWidth-1:0]   cur_item_val;
  logic [DataWidth-1:0]   item_out_val;
  logic [DataWidth-1:0]   elem_out_val;

  // result queue
  res_t                   q_ent_q [QueueDepth];
  logic [DataWidth-1:0]   q_val_q [QueueDepth];
  logic [PtrWidth-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]    count_q;
  logic                   pop;

  // configuration writes and reads
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      legacy_q  <= 1'b0;
      max_len_q <= MaxLenReset[LengthWidth-1:0];
    end else if (cfg_write) begin
      if (paddr[2] == RegLegacy) begin
        legacy_q <= pwdata[0];
      end else begin
        max_len_q <= pwdata[LengthWidth-1:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      RegLegacy: prdata = {31'd0, legacy_q};
      RegMaxLen: prdata = {1'b0, max_len_q};
      default:   prdata = '0;
    endcase
  end

  // input register, freed when the item is processed
  assign proc       = in_valid_q && (count_q <= CntWidth'(QueueDepth - MaxResults));
  assign in_stall_o = in_valid_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q       <= command_i;
      pos_q       <= position_i;
      pos_null_q  <= position_null_i;
      arr_null_q  <= array_null_i;
      len_q       <= source_length_i;
      item_val_q  <= item_value_i[DataWidth-1:0];
      item_null_q <= item_null_i;
      elem_val_q  <= element_value_i[DataWidth-1:0];
      elem_null_q <= element_null_i;
    end
  end

  // header placement: mode, slot and result length
  assign pos_s        = ArithWidth'(signed'(pos_q));
  assign len_s        = signed'(ArithWidth'(len_q));
  assign max_s        = signed'(ArithWidth'(max_len_q));
  assign idx_s        = pos_s - ArithWidth'(1);
  assign neg_s        = -pos_s;
  assign pos_positive = !pos_q[PosWidth-1] && (pos_q != '0);

  always_comb begin
    if (pos_positive) begin
      if (idx_s <= len_s) begin
        mode_hdr   = MODE_AT_SLOT;
        slot_hdr   = idx_s;
        newlen_hdr = len_s + ArithWidth'(1);
      end else begin
        mode_hdr   = MODE_PAD_AFTER;
        slot_hdr   = idx_s - len_s;
        newlen_hdr = pos_s;
      end
    end else if (neg_s > len_s) begin
      mode_hdr   = MODE_PAD_BEFORE;
      newlen_hdr = neg_s + signed'(ArithWidth'(legacy_q));
      slot_hdr   = neg_s + signed'(ArithWidth'(legacy_q)) - ArithWidth'(1) - len_s;
    end else begin
      mode_hdr   = MODE_AT_SLOT;
      slot_hdr   = pos_s + len_s + signed'(ArithWidth'(!legacy_q));
      newlen_hdr = len_s + ArithWidth'(1);
    end
  end

  assign too_long = newlen_hdr > max_s;

  // element position within the row
  assign c_inc      = {1'b0, counter_q} + (LengthWidth + 1)'(1);
  assign final_elem = c_inc == {1'b0, row_len_q};

  // item to insert: straight from the header, else the held copy
  assign cur_item_val  = (cmd_q == CmdHeader) ? item_val_q : held_item_q;
  assign cur_item_null = (cmd_q == CmdHeader) ? item_null_q : held_null_q;
  assign item_out_val  = cur_item_null ? '0 : cur_item_val;
  assign elem_out_val  = elem_null_q ? '0 : elem_val_q;

  function automatic res_t mk_res(kind_e kind, logic nul, logic [LengthWidth-1:0] rep,
                                  logic rend);
    res_t r;
    r.kind         = kind;
    r.out_null     = nul;
    r.repeat_count = rep;
    r.row_end      = rend;
    r.last         = 1'b0;
    return r;
  endfunction

  // results and next row state for the item in the input register
  always_comb begin
    row_len_d   = row_len_q;
    held_item_d = held_item_q;
    held_null_d = held_null_q;
    counter_d   = counter_q;
    slot_d      = slot_q;
    mode_d      = mode_q;
    drop_d      = drop_q;
    n_res       = 2'd0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i]     = '0;
      res_val[i] = '0;
    end

    if (cmd_q == CmdHeader) begin
      row_len_d   = len_q;
      held_item_d = item_val_q;
      held_null_d = item_null_q;
      counter_d   = '0;
      mode_d      = MODE_IDLE;
      drop_d      = 1'b0;
      if (arr_null_q || pos_null_q) begin
        res[0] = mk_res(KIND_NULL_ROW, 1'b1, LengthWidth'(1), 1'b1);
        n_res  = 2'd1;
        drop_d = 1'b1;
      end else if (pos_q == '0) begin
        res[0] = mk_res(KIND_ZERO_POS, 1'b0, LengthWidth'(1), 1'b1);
        n_res  = 2'd1;
        drop_d = 1'b1;
      end else if (too_long) begin
        res[0] = mk_res(KIND_TOO_LONG, 1'b0, LengthWidth'(1), 1'b1);
        n_res  = 2'd1;
        drop_d = 1'b1;
      end else begin
        slot_d = slot_hdr[PosWidth-1:0];
        case (mode_hdr)
          MODE_AT_SLOT: begin
            if (slot_hdr == '0) begin
              res[0]     = mk_res(KIND_RUN, cur_item_null, LengthWidth'(1), len_q == '0);
              res_val[0] = item_out_val;
              n_res      = 2'd1;
            end
          end
          MODE_PAD_AFTER: begin
            if (len_q == '0) begin
              res[0]     = mk_res(KIND_RUN, 1'b1, slot_hdr[LengthWidth-1:0], 1'b0);
              res[1]     = mk_res(KIND_RUN, cur_item_null, LengthWidth'(1), 1'b1);
              res_val[1] = item_out_val;
              n_res      = 2'd2;
            end
          end
          MODE_PAD_BEFORE: begin
            res[0]     = mk_res(KIND_RUN, cur_item_null, LengthWidth'(1),
                                (slot_hdr == '0) && (len_q == '0));
            res_val[0] = item_out_val;
            n_res      = 2'd1;
            if (slot_hdr != '0) begin
              res[1] = mk_res(KIND_RUN, 1'b1, slot_hdr[LengthWidth-1:0], len_q == '0);
              n_res  = 2'd2;
            end
          end
          default: ;
        endcase
        mode_d = (len_q == '0) ? MODE_IDLE : mode_hdr;
      end
    end else if (!drop_q && (mode_q != MODE_IDLE)) begin
      case (mode_q)
        MODE_AT_SLOT: begin
          if (({1'b0, counter_q} == slot_q) && (slot_q != '0)) begin
            res[0]     = mk_res(KIND_RUN, cur_item_null, LengthWidth'(1), 1'b0);
            res_val[0] = item_out_val;
            res[1]     = mk_res(KIND_RUN, elem_null_q, LengthWidth'(1),
                                final_elem && (slot_q != {1'b0, row_len_q}));
            res_val[1] = elem_out_val;
            n_res      = 2'd2;
          end else begin
            res[0]     = mk_res(KIND_RUN, elem_null_q, LengthWidth'(1),
                                final_elem && (slot_q != {1'b0, row_len_q}));
            res_val[0] = elem_out_val;
            n_res      = 2'd1;
            if (final_elem && (slot_q == {1'b0, row_len_q})) begin
              res[1]     = mk_res(KIND_RUN, cur_item_null, LengthWidth'(1), 1'b1);
              res_val[1] = item_out_val;
              n_res      = 2'd2;
            end
          end
        end
        MODE_PAD_AFTER: begin
          res[0]     = mk_res(KIND_RUN, elem_null_q, LengthWidth'(1), 1'b0);
          res_val[0] = elem_out_val;
          n_res      = 2'd1;
          if (final_elem) begin
            res[1]     = mk_res(KIND_RUN, 1'b1, slot_q[LengthWidth-1:0], 1'b0);
            res[2]     = mk_res(KIND_RUN, cur_item_null, LengthWidth'(1), 1'b1);
            res_val[2] = item_out_val;
            n_res      = 2'd3;
          end
        end
        default: begin
          res[0]     = mk_res(KIND_RUN, elem_null_q, LengthWidth'(1), final_elem);
          res_val[0] = elem_out_val;
          n_res      = 2'd1;
        end
      endcase
      counter_d = c_inc[LengthWidth-1:0];
      if (c_inc[LengthWidth-1:0] >= row_len_q) begin
        mode_d = MODE_IDLE;
      end
    end

    // mark the final result of this item
    for (int i = 0; i < MaxResults; i++) begin
      res[i].last = (2'(i) == n_res - 2'd1) && (n_res != 2'd0);
    end
  end

  // row state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q   <= '0;
      held_item_q <= '0;
      held_null_q <= 1'b0;
      counter_q   <= '0;
      slot_q      <= '0;
      mode_q      <= MODE_IDLE;
      drop_q      <= 1'b0;
    end else if (proc) begin
      row_len_q   <= row_len_d;
      held_item_q <= held_item_d;
      held_null_q <= held_null_d;
      counter_q   <= counter_d;
      slot_q      <= slot_d;
      mode_q      <= mode_d;
      drop_q      <= drop_d;
    end
  end

  // result queue control
  assign pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (proc) begin
        wr_ptr_q <= wr_ptr_q + PtrWidth'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrWidth'(1);
      end
      count_q <= count_q + (proc ? CntWidth'(n_res) : '0) - (pop ? CntWidth'(1) : '0);
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (proc) begin
      for (int i = 0; i < MaxResults; i++) begin
        if (2'(i) < n_res) begin
          q_ent_q[wr_ptr_q + PtrWidth'(i)] <= res[i];
          q_val_q[wr_ptr_q + PtrWidth'(i)] <= res_val[i];
        end
      end
    end
  end

  // output transfer
  assign out_valid_o    = count_q != '0;
  assign kind_o         = q_ent_q[rd_ptr_q].kind;
  assign out_value_o    = ValueWidth'(q_val_q[rd_ptr_q]);
  assign out_null_o     = q_ent_q[rd_ptr_q].out_null;
  assign repeat_count_o = q_ent_q[rd_ptr_q].repeat_count;
  assign row_end_o      = q_ent_q[rd_ptr_q].row_end;
  assign last_o         = q_ent_q[rd_ptr_q].last;

  // queue never overruns its depth
  `AEIS_NEVER(a_queue_room, proc && (count_q + CntWidth'(n_res) > QueueFull), "queue overrun")
  // a dropped row never stays open
  `AEIS_NEVER(a_drop_closed, drop_q && (mode_q != MODE_IDLE), "dropped row left open")
  // a processed header restarts the element count
  `AEIS_ASSERT(a_hdr_count, proc && cmd_q == CmdHeader |=> counter_q == '0, "count not cleared")

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the array insert splicer core: a queue-fed driver
// streams row headers and elements with random gaps, a predictor computes the
// spliced rows, and a monitor with random stalls compares every result.
// ----------------------------------------------------------------------------
module tb;
  import aeis_pkg::*;

  localparam int ClkPeriod   = 20;
  localparam int StuckLimit  = 2000;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 120;
  localparam int RandPhases  = 6;
  localparam int RowsBudget  = 50;

  localparam logic [2:0] AddrLegacy = {RegLegacy, 2'b00};
  localparam logic [2:0] AddrMaxLen = {RegMaxLen, 2'b00};

  localparam logic [LengthWidth-1:0] MaxLenTop = MaxLenReset[LengthWidth-1:0];
  localparam logic [ValueWidth-1:0]  ValueMask =
    {ValueWidth{1'b1}} >> (ValueWidth - DataWidthDefault);

  // one input transfer
  typedef struct {
    logic                       command;
    logic signed [PosWidth-1:0] position;
    logic                       position_null;
    logic                       array_null;
    logic [LengthWidth-1:0]     source_length;
    logic [ValueWidth-1:0]      item_value;
    logic                       item_null;
    logic [ValueWidth-1:0]      element_value;
    logic                       element_null;
  } splice_in_t;

  // one result transfer
  typedef struct {
    kind_e                  kind;
    logic [ValueWidth-1:0]  value;
    logic                   null_flag;
    logic [LengthWidth-1:0] repeat_count;
    logic                   row_end;
    logic                   last;
  } splice_out_t;

  // dut ports
  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic                       command_i       = 1'b0;
  logic signed [PosWidth-1:0] position_i      = '0;
  logic                       position_null_i = 1'b0;
  logic                       array_null_i    = 1'b0;
  logic [LengthWidth-1:0]     source_length_i = '0;
  logic [ValueWidth-1:0]      item_value_i    = '0;
  logic                       item_null_i     = 1'b0;
  logic [ValueWidth-1:0]      element_value_i = '0;
  logic                       element_null_i  = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic [1:0]                 kind_o;
  logic [ValueWidth-1:0]      out_value_o;
  logic                       out_null_o;
  logic [LengthWidth-1:0]     repeat_count_o;
  logic                       row_end_o;
  logic                       last_o;
  logic                       psel            = 1'b0;
  logic                       penable         = 1'b0;
  logic                       pwrite          = 1'b0;
  logic [2:0]                 paddr           = '0;
  logic [31:0]                pwdata          = '0;
  logic [31:0]                prdata;
  logic                       pready;

  array_element_insert_splicer_core uut (.*);

  // stream of rows waiting for the driver, and spliced results still owed
  splice_in_t  array_stream[$];
  splice_out_t expected_splice_out[$];

  // register copies and open-row state of the predictor
  logic                   cfg_legacy      = 1'b0;
  logic [LengthWidth-1:0] cfg_max_len     = MaxLenTop;
  logic [LengthWidth-1:0] row_len_q       = '0;
  logic [LengthWidth-1:0] elem_count_q    = '0;
  logic [ValueWidth-1:0]  row_item_q      = '0;
  logic                   row_item_null_q = 1'b0;
  logic                   row_dropped_q   = 1'b0;
  longint                 row_slot_q      = 0;
  row_mode_e              row_mode_q      = MODE_IDLE;

  // run bookkeeping
  int mismatches      = 0;
  int items_accepted  = 0;
  int results_checked = 0;
  int settings_done   = 0;
  int kind_count[4]   = '{default: 0};
  int tx_gap_max      = 15;
  int rx_gap_max      = 15;

  // clock
  initial begin : clock_gen
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic splice_in_t hdr(logic signed [PosWidth-1:0] pos, logic pnull,
                                     logic anull, logic [LengthWidth-1:0] len,
                                     logic [ValueWidth-1:0] val, logic vnull);
    splice_in_t it;
    it.command       = CmdHeader;
    it.position      = pos;
    it.position_null = pnull;
    it.array_null    = anull;
    it.source_length = len;
    it.item_value    = val;
    it.item_null     = vnull;
    // element fields are ignored on a header, so fill them with noise
    it.element_value = {$urandom, $urandom};
    it.element_null  = 1'($urandom);
    return it;
  endfunction

  function automatic splice_in_t elem(logic [ValueWidth-1:0] val, logic vnull);
    splice_in_t it;
    // header fields are ignored on an element
    it.command       = CmdElement;
    it.position      = $urandom;
    it.position_null = 1'($urandom);
    it.array_null    = 1'($urandom);
    it.source_length = LengthWidth'($urandom);
    it.item_value    = {$urandom, $urandom};
    it.item_null     = 1'($urandom);
    it.element_value = val;
    it.element_null  = vnull;
    return it;
  endfunction

  function automatic void add_expected(kind_e k, logic [ValueWidth-1:0] v, logic nl,
                                       logic [LengthWidth-1:0] rep, logic rend);
    splice_out_t r;
    r.kind         = k;
    r.value        = nl ? '0 : (v & ValueMask);
    r.null_flag    = nl;
    r.repeat_count = rep;
    r.row_end      = rend;
    r.last         = 1'b0;
    expected_splice_out.push_back(r);
  endfunction

  function automatic void add_held_item(logic rend);
    add_expected(KIND_RUN, row_item_q, row_item_null_q, 1, rend);
  endfunction

  // splice prediction for one accepted input transfer
  function automatic void predict_splice(splice_in_t it);
    int          first;
    longint      p;
    longint      l;
    longint      newlen;
    longint      slot;
    row_mode_e   mode;
    logic        fin;
    splice_out_t tail;
    first = expected_splice_out.size();
    if (it.command == CmdHeader) begin
      p      = it.position;
      l      = longint'(it.source_length);
      mode   = MODE_IDLE;
      slot   = 0;
      newlen = 0;
      row_len_q       = it.source_length;
      row_item_q      = it.item_value & ValueMask;
      row_item_null_q = it.item_null;
      elem_count_q    = '0;
      row_mode_q      = MODE_IDLE;
      row_dropped_q   = 1'b0;
      // null flags win over every other check
      if (it.array_null || it.position_null) begin
        add_expected(KIND_NULL_ROW, '0, 1'b1, 1, 1'b1);
        row_dropped_q = 1'b1;
      end else if (p == 0) begin
        add_expected(KIND_ZERO_POS, '0, 1'b0, 1, 1'b1);
        row_dropped_q = 1'b1;
      end else begin
        if (p > 0) begin
          if (p - 1 <= l) begin
            mode = MODE_AT_SLOT;
            slot = p - 1;
            newlen = l + 1;
          end else begin
            mode = MODE_PAD_AFTER;
            slot = p - 1 - l;
            newlen = p;
          end
        end else if (-p > l) begin
          // reaches past the start: item, null run, then the elements
          mode = MODE_PAD_BEFORE;
          newlen = -p + longint'(cfg_legacy);
          slot = newlen - 1 - l;
        end else begin
          mode = MODE_AT_SLOT;
          slot = p + l + (cfg_legacy ? 0 : 1);
          newlen = l + 1;
        end
        if (newlen > longint'(cfg_max_len)) begin
          add_expected(KIND_TOO_LONG, '0, 1'b0, 1, 1'b1);
          row_dropped_q = 1'b1;
        end else begin
          row_slot_q = slot;
          case (mode)
            MODE_AT_SLOT: begin
              if (slot == 0) add_held_item(l == 0);
            end
            MODE_PAD_AFTER: begin
              if (l == 0) begin
                add_expected(KIND_RUN, '0, 1'b1, LengthWidth'(slot), 1'b0);
                add_held_item(1'b1);
              end
            end
            default: begin
              add_held_item(slot == 0 && l == 0);
              if (slot > 0) add_expected(KIND_RUN, '0, 1'b1, LengthWidth'(slot), l == 0);
            end
          endcase
          row_mode_q = (l == 0) ? MODE_IDLE : mode;
        end
      end
    end else if (!row_dropped_q && row_mode_q != MODE_IDLE) begin
      fin = (longint'(elem_count_q) + 1 == longint'(row_len_q));
      case (row_mode_q)
        MODE_AT_SLOT: begin
          if (longint'(elem_count_q) == row_slot_q && row_slot_q != 0) add_held_item(1'b0);
          add_expected(KIND_RUN, it.element_value, it.element_null, 1,
                       fin && row_slot_q != longint'(row_len_q));
          if (fin && row_slot_q == longint'(row_len_q)) add_held_item(1'b1);
        end
        MODE_PAD_AFTER: begin
          add_expected(KIND_RUN, it.element_value, it.element_null, 1, 1'b0);
          if (fin) begin
            add_expected(KIND_RUN, '0, 1'b1, LengthWidth'(row_slot_q), 1'b0);
            add_held_item(1'b1);
          end
        end
        default: begin
          add_expected(KIND_RUN, it.element_value, it.element_null, 1, fin);
        end
      endcase
      elem_count_q = elem_count_q + 1'b1;
      if (elem_count_q >= row_len_q) row_mode_q = MODE_IDLE;
    end
    // flag the final result of this transfer
    if (expected_splice_out.size() > first) begin
      tail = expected_splice_out.pop_back();
      tail.last = 1'b1;
      expected_splice_out.push_back(tail);
    end
  endfunction

  // input driver
  splice_in_t tx_item  = '{default: '0};
  logic       tx_busy  = 1'b0;
  int         tx_pause = 0;

  always @(posedge clk_i) begin : item_drive
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_splice(tx_item);
        items_accepted++;
        tx_busy  = 1'b0;
        tx_pause = $urandom_range(0, tx_gap_max);
      end
      if (!tx_busy && tx_pause == 0 && array_stream.size() > 0) begin
        tx_item = array_stream.pop_front();
        tx_busy = 1'b1;
      end else if (!tx_busy && tx_pause > 0) begin
        tx_pause--;
      end
      in_valid_i      <= tx_busy;
      command_i       <= tx_item.command;
      position_i      <= tx_item.position;
      position_null_i <= tx_item.position_null;
      array_null_i    <= tx_item.array_null;
      source_length_i <= tx_item.source_length;
      item_value_i    <= tx_item.item_value;
      item_null_i     <= tx_item.item_null;
      element_value_i <= tx_item.element_value;
      element_null_i  <= tx_item.element_null;
    end
  end

  // result monitor with random stalls and two long hold-offs
  int rx_pause  = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin : result_check
    splice_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        kind_count[kind_o]++;
        if (expected_splice_out.size() == 0) begin
          $error("unexpected result transfer: kind %0d value %0h", kind_o, out_value_o);
          mismatches++;
        end else begin
          want = expected_splice_out.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind expected %0d actual %0d", want.kind, kind_o);
            mismatches++;
          end
          if (out_value_o !== want.value) begin
            $error("out_value expected %0h actual %0h", want.value, out_value_o);
            mismatches++;
          end
          if (out_null_o !== want.null_flag) begin
            $error("out_null expected %0b actual %0b", want.null_flag, out_null_o);
            mismatches++;
          end
          if (repeat_count_o !== want.repeat_count) begin
            $error("repeat_count expected %0d actual %0d", want.repeat_count, repeat_count_o);
            mismatches++;
          end
          if (row_end_o !== want.row_end) begin
            $error("row_end expected %0b actual %0b", want.row_end, row_end_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $error("last expected %0b actual %0b", want.last, last_o);
            mismatches++;
          end
        end
        results_checked++;
        // back-pressure long enough to fill the block and stall its input
        if (results_checked == 60 || results_checked == 260) hold_left = HoldCycles;
        rx_pause = $urandom_range(0, rx_gap_max);
      end else if (rx_pause > 0) begin
        rx_pause--;
      end
      if (hold_left > 0) hold_left--;
      out_stall_i <= (rx_pause != 0) || (hold_left != 0);
    end
  end

  // watchdog on cycles without any transfer
  int stuck_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel || !rst_ni)
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("no transfer for %0d cycles, %0d results still owed",
               StuckLimit, expected_splice_out.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // register write, then read back
  task automatic write_setting(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] want;
    want = (addr == AddrLegacy) ? {31'b0, value[0]} : {1'b0, value[LengthWidth-1:0]};
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == AddrLegacy) cfg_legacy = value[0];
    else cfg_max_len = value[LengthWidth-1:0];
    settings_done++;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $error("register at %0d readback expected %0h actual %0h", addr, want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until the stream is sent and every result is back
  task automatic drain_stream();
    while (array_stream.size() != 0 || tx_busy || expected_splice_out.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly well-formed rows with random content, some broken or stray
  task automatic queue_random_rows(input int budget);
    int                         added;
    int                         n_el;
    int                         span;
    int                         pick;
    int                         k;
    logic [LengthWidth-1:0]     len;
    logic signed [PosWidth-1:0] pos;
    added = 0;
    while (added < budget) begin
      if ($urandom_range(0, 24) == 0)
        array_stream.push_back(elem({$urandom, $urandom}, 1'($urandom)));
      len = ($urandom_range(0, 9) == 0) ? LengthWidth'($urandom)
                                         : LengthWidth'($urandom_range(0, 8));
      span = (len > 8) ? 12 : int'(len) + 4;
      pick = $urandom_range(0, 19);
      if (pick == 0) pos = '0;
      else if (pick < 3) pos = $urandom;
      else pos = $urandom_range(0, 2 * span) - span;
      array_stream.push_back(hdr(pos, $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0,
                                 len, {$urandom, $urandom}, $urandom_range(0, 7) == 0));
      n_el = (len > 8) ? $urandom_range(0, 3) : int'(len);
      // cut short or with surplus elements
      if ($urandom_range(0, 9) == 0) n_el = $urandom_range(0, n_el + 2);
      for (k = 0; k < n_el; k++)
        array_stream.push_back(elem({$urandom, $urandom}, $urandom_range(0, 4) == 0));
      added += 1 + n_el;
    end
  endtask

  initial begin : stimulus
    int ph;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows at the widest limit, standard negative placement
    write_setting(AddrLegacy, 32'd0);
    write_setting(AddrMaxLen, {1'b0, MaxLenTop});
    // element with no open row
    array_stream.push_back(elem(64'h0123_4567_89ab_cdef, 1'b0));
    // empty source, the item is the whole row
    array_stream.push_back(hdr(1, 1'b0, 1'b0, 0, '1, 1'b0));
    // item in the middle
    array_stream.push_back(hdr(2, 1'b0, 1'b0, 2, 64'h5555_5555_5555_5555, 1'b0));
    array_stream.push_back(elem('1, 1'b0));
    array_stream.push_back(elem('1, 1'b1));
    // past the end, nulls pad the gap
    array_stream.push_back(hdr(4, 1'b0, 1'b0, 1, 64'haaaa_aaaa_aaaa_aaaa, 1'b0));
    array_stream.push_back(elem(64'h1, 1'b0));
    // longest allowed row as one null run and a null item
    array_stream.push_back(hdr(32'sd2147483632, 1'b0, 1'b0, 0, 64'h8000_0000_0000_0001, 1'b1));
    // negative position beyond the start
    array_stream.push_back(hdr(-4, 1'b0, 1'b0, 1, 64'hdead_beef_0000_ffff, 1'b0));
    array_stream.push_back(elem(64'h0, 1'b0));
    // negative position inside the row, item goes last
    array_stream.push_back(hdr(-1, 1'b0, 1'b0, 1, 64'h0, 1'b0));
    array_stream.push_back(elem(64'hffff_0000_ffff_0000, 1'b0));
    // null array beats position zero, element dropped
    array_stream.push_back(hdr(0, 1'b0, 1'b1, 1, 64'h1234, 1'b0));
    array_stream.push_back(elem(64'h77, 1'b0));
    // null position
    array_stream.push_back(hdr(5, 1'b1, 1'b0, 0, 64'h99, 1'b0));
    // position zero, element dropped
    array_stream.push_back(hdr(0, 1'b0, 1'b0, 1, 64'h42, 1'b0));
    array_stream.push_back(elem(64'h43, 1'b0));
    // position extremes are too long
    array_stream.push_back(hdr(32'h7fff_ffff, 1'b0, 1'b0, 0, 64'h1, 1'b0));
    array_stream.push_back(hdr(32'h8000_0000, 1'b0, 1'b0, 0, 64'h2, 1'b0));
    // longest source length overflows the limit by one
    array_stream.push_back(hdr(1, 1'b0, 1'b0, MaxLenTop, 64'h3, 1'b0));
    array_stream.push_back(elem(64'h4, 1'b0));
    // surplus element after the row is complete
    array_stream.push_back(hdr(1, 1'b0, 1'b0, 1, 64'h5, 1'b0));
    array_stream.push_back(elem(64'h6, 1'b1));
    array_stream.push_back(elem(64'h7, 1'b0));
    // a new header abandons the open row
    array_stream.push_back(hdr(3, 1'b0, 1'b0, 2, 64'h8, 1'b0));
    array_stream.push_back(elem(64'h9, 1'b0));
    array_stream.push_back(hdr(-1, 1'b0, 1'b0, 0, 64'ha, 1'b1));
    drain_stream();

    // legacy negative placement with a tight limit
    write_setting(AddrLegacy, 32'd1);
    write_setting(AddrMaxLen, 32'd2);
    array_stream.push_back(hdr(-1, 1'b0, 1'b0, 1, 64'hb, 1'b0));
    array_stream.push_back(elem(64'hc, 1'b0));
    array_stream.push_back(hdr(-1, 1'b0, 1'b0, 0, 64'hd, 1'b0));
    array_stream.push_back(hdr(-2, 1'b0, 1'b0, 0, 64'he, 1'b0));
    array_stream.push_back(hdr(-2, 1'b0, 1'b0, 2, 64'hf, 1'b0));
    array_stream.push_back(elem(64'h10, 1'b0));
    drain_stream();

    // smallest legal limit
    write_setting(AddrLegacy, 32'd0);
    write_setting(AddrMaxLen, 32'd1);
    array_stream.push_back(hdr(1, 1'b0, 1'b0, 0, 64'h11, 1'b0));
    array_stream.push_back(hdr(-1, 1'b0, 1'b0, 0, 64'h12, 1'b0));
    array_stream.push_back(hdr(2, 1'b0, 1'b0, 0, 64'h13, 1'b0));
    drain_stream();

    // zero limit, every row too long unless flagged earlier
    write_setting(AddrMaxLen, 32'd0);
    array_stream.push_back(hdr(1, 1'b0, 1'b0, 0, 64'h14, 1'b0));
    array_stream.push_back(hdr(0, 1'b0, 1'b0, 0, 64'h15, 1'b0));
    drain_stream();

    // random phases, each with its own settings and idling mix
    for (ph = 0; ph < RandPhases; ph++) begin
      tx_gap_max = (ph % 2 == 0) ? 15 : 0;
      rx_gap_max = (ph % 4 < 2) ? 15 : 0;
      write_setting(AddrLegacy, $urandom_range(0, 1));
      if (ph == 0 || $urandom_range(0, 2) == 0)
        write_setting(AddrMaxLen, {1'b0, MaxLenTop});
      else
        write_setting(AddrMaxLen, $urandom_range(1, 40));
      queue_random_rows(RowsBudget);
      drain_stream();
    end

    $display("covered %0d input transfers, %0d results checked, %0d register writes",
             items_accepted, results_checked, settings_done);
    $display("result kinds: runs %0d, null rows %0d, zero position %0d, too long %0d",
             kind_count[KIND_RUN], kind_count[KIND_NULL_ROW],
             kind_count[KIND_ZERO_POS], kind_count[KIND_TOO_LONG]);
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

/* array_element_insert_splicer_core.f */
+incdir+src
src/aeis_pkg.sv
src/array_element_insert_splicer_core.sv
tb/sv/tb.sv
